// ===== hdl/ppm_pkg.sv =====
package ppm_pkg;

    localparam int CHANNELS_DEFAULT   = 8;
    localparam int COEFF_FRAC_DEFAULT = 24;

    localparam int CH_W        = 3;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 17;
    localparam int LEVEL_W     = 40;
    localparam int LEVEL_FRAC  = 24;
    localparam int PEAK_W      = 16;
    localparam int REG_W       = 24;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    localparam logic [REG_W-1:0] ATTACK_RESET  = 24'd83486;
    localparam logic [REG_W-1:0] RELEASE_RESET = 24'd558;

    typedef enum logic [0:0] {
        REG_ATTACK  = 1'b0,
        REG_RELEASE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PEAK_W-1:0]  peak;
    } entry_t;

endpackage

// ===== hdl/ppm_state_mem.sv =====
module ppm_state_mem #(
    parameter int DEPTH = ppm_pkg::CHANNELS_DEFAULT,
    parameter int AW    = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output ppm_pkg::entry_t  rd_entry,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  ppm_pkg::entry_t  wr_entry
);

    ppm_pkg::entry_t   mem [DEPTH];
    ppm_pkg::entry_t   rd_data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry that was never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/ppm_scale_mul.sv =====
module ppm_scale_mul #(
    parameter int COEFF_FRAC_BITS = ppm_pkg::COEFF_FRAC_DEFAULT,
    parameter int CW              = 25
) (
    input  logic                         clk,
    input  logic                         ld_part,
    input  logic [ppm_pkg::LEVEL_W-1:0]  a,
    input  logic [CW-1:0]                c,
    input  logic                         ld_sum,
    output logic [ppm_pkg::LEVEL_W-1:0]  prod
);

    localparam int HALF = ppm_pkg::LEVEL_W / 2;
    localparam int PW   = HALF + CW;
    localparam int SW   = ppm_pkg::LEVEL_W + CW;

    logic [PW-1:0]               hi_reg;
    logic [PW-1:0]               lo_reg;
    logic [ppm_pkg::LEVEL_W-1:0] prod_reg;
    logic [PW-1:0]               hi_next;
    logic [PW-1:0]               lo_next;
    logic [SW-1:0]               sum;
    logic [ppm_pkg::LEVEL_W-1:0] prod_next;

    // The 40-bit operand is split in halves so that each product is at most 20 by 25 bits.
    assign hi_next   = PW'(a[ppm_pkg::LEVEL_W-1:HALF]) * PW'(c);
    assign lo_next   = PW'(a[HALF-1:0]) * PW'(c);
    assign sum       = (SW'(hi_reg) << HALF) + SW'(lo_reg);
    assign prod_next = ppm_pkg::LEVEL_W'(sum >> COEFF_FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (ld_part)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
        if (ld_sum)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/peak_programme_meter_unit.sv =====
// Multichannel peak meter with attack and release smoothing.
// Input channel s_*: s_tdata carries the channel number and a signed 16-bit sample,
// s_tlast marks the last word of a processing block and is passed through to m_tlast.
// Output channel m_*: one word per input word, in input order, carrying the channel,
// the integer part of the new level, a rising flag and the channel's held peak.
// The configuration port writes the attack and release coefficients; write it only
// while no word is in flight.
// Throughput: one word per cycle while the output is not stalled and no word names the
// channel of one of the words still ahead of it in the four pipeline stages.
// The state of each channel lives in a one-port-read, one-port-write memory and goes
// through a four-stage read, multiply, sum and update pipeline; a word whose channel
// is still in that pipeline waits.
// Reset clears all levels and held peaks at once and restores the default coefficients.
// When the receiver stalls, the output register holds its word and the stages behind
// it keep filling; input is refused once every stage is occupied, or earlier while the
// offered word's channel is still in the pipeline.
module peak_programme_meter_unit #(
    parameter int CHANNELS        = ppm_pkg::CHANNELS_DEFAULT,
    parameter int COEFF_FRAC_BITS = ppm_pkg::COEFF_FRAC_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppm_pkg::S_TDATA_W-1:0]  s_tdata,  // channel[2:0], sample[18:3]
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_channel[2:0], level[18:3], rising[19], held_peak[35:20]
    output logic [ppm_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [ppm_pkg::REG_W-1:0]      cfg_data
);

    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW   = COEFF_FRAC_BITS + 1;
    localparam int CMPW = (CW > ppm_pkg::REG_W) ? CW : ppm_pkg::REG_W;
    localparam logic [CMPW-1:0] ONE_EXT = CMPW'(1) << COEFF_FRAC_BITS;
    localparam logic [CW-1:0]   ONE_C   = CW'(1) << COEFF_FRAC_BITS;
    localparam int LW = ppm_pkg::LEVEL_W;
    localparam int LF = ppm_pkg::LEVEL_FRAC;
    localparam int PKW = ppm_pkg::PEAK_W;

    typedef struct packed {
        logic [ppm_pkg::CH_W-1:0] ch;
        logic                     be;
        logic                     inr;
        logic                     atk;
        logic [LW-1:0]            prev;
        logic [PKW-1:0]           peak;
    } meta_t;

    logic [ppm_pkg::REG_W-1:0] atk_reg;
    logic [ppm_pkg::REG_W-1:0] rel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atk_reg <= ppm_pkg::ATTACK_RESET;
            rel_reg <= ppm_pkg::RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppm_pkg::REG_ATTACK:  atk_reg <= cfg_data;
                ppm_pkg::REG_RELEASE: rel_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    logic [CMPW-1:0] atk_ext;
    logic [CMPW-1:0] rel_ext;
    logic [CW-1:0]   atk_c;
    logic [CW-1:0]   rel_c;
    logic [CW-1:0]   rel_factor;

    assign atk_ext    = CMPW'(atk_reg);
    assign rel_ext    = CMPW'(rel_reg);
    assign atk_c      = (atk_ext > ONE_EXT) ? ONE_C : CW'(atk_ext);
    assign rel_c      = (rel_ext > ONE_EXT) ? ONE_C : CW'(rel_ext);
    assign rel_factor = ONE_C - rel_c;

    logic [ppm_pkg::CH_W-1:0]     in_ch;
    logic [ppm_pkg::SAMPLE_W-1:0] in_sample;
    logic                         in_inr;

    assign in_ch     = s_tdata[ppm_pkg::CH_W-1:0];
    assign in_sample = s_tdata[ppm_pkg::CH_W +: ppm_pkg::SAMPLE_W];
    assign in_inr    = (32'(in_ch) < 32'(CHANNELS));

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic ld1, ld2, ld3, ld4, ld_out;
    logic hazard;
    logic accept;

    logic [ppm_pkg::CH_W-1:0]  ch1_reg;
    logic [ppm_pkg::MAG_W-1:0] mag1_reg;
    logic                      be1_reg;
    logic                      inr1_reg;
    meta_t                     meta2_reg;
    meta_t                     meta3_reg;
    meta_t                     meta4_reg;
    logic [LW-1:0]             a2_reg;
    logic [CW-1:0]             c2_reg;

    assign ld_out = !out_v_reg || m_tready;
    assign ld4    = !v4_reg || ld_out;
    assign ld3    = !v3_reg || ld4;
    assign ld2    = !v2_reg || ld3;
    assign ld1    = !v1_reg || ld2;

    // A word may not read a channel whose update is still in the pipeline.
    assign hazard = in_inr && (
        (v1_reg && inr1_reg && (ch1_reg == in_ch)) ||
        (v2_reg && meta2_reg.inr && (meta2_reg.ch == in_ch)) ||
        (v3_reg && meta3_reg.inr && (meta3_reg.ch == in_ch)) ||
        (v4_reg && meta4_reg.inr && (meta4_reg.ch == in_ch)));

    assign s_tready = ld1 && !hazard;
    assign accept   = s_tvalid && s_tready;

    logic [ppm_pkg::MAG_W-1:0] mag_next;

    assign mag_next = in_sample[ppm_pkg::SAMPLE_W-1]
                    ? (ppm_pkg::MAG_W'(17'h10000) - ppm_pkg::MAG_W'(in_sample))
                    : ppm_pkg::MAG_W'(in_sample);

    ppm_pkg::entry_t rd_entry;
    ppm_pkg::entry_t wr_entry;
    logic            wr_en;

    ppm_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept && in_inr),
        .rd_addr  (AW'(in_ch)),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (AW'(meta4_reg.ch)),
        .wr_entry (wr_entry)
    );

    logic [LW-1:0] m1;
    logic          atk1;
    meta_t         meta2_next;
    logic [LW-1:0] a2_next;
    logic [CW-1:0] c2_next;

    assign m1   = LW'(mag1_reg) << LF;
    assign atk1 = !(rd_entry.level > m1);

    always_comb
    begin
        meta2_next.ch   = ch1_reg;
        meta2_next.be   = be1_reg;
        meta2_next.inr  = inr1_reg;
        meta2_next.atk  = atk1;
        meta2_next.prev = rd_entry.level;
        meta2_next.peak = rd_entry.peak;
        a2_next         = atk1 ? (m1 - rd_entry.level) : rd_entry.level;
        c2_next         = atk1 ? atk_c : rel_factor;
    end

    logic [LW-1:0] prod;

    ppm_scale_mul #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .CW              (CW)
    ) u_mul (
        .clk     (clk),
        .ld_part (ld3 && v2_reg),
        .a       (a2_reg),
        .c       (c2_reg),
        .ld_sum  (ld4 && v3_reg),
        .prod    (prod)
    );

    logic [LW-1:0]               level_next;
    logic                        rise;
    logic [PKW-1:0]              peak_next;
    logic [ppm_pkg::M_TDATA_W-1:0] out_tdata_next;
    logic [ppm_pkg::M_TDATA_W-1:0] out_tdata_reg;
    logic                        out_tlast_reg;

    always_comb
    begin
        level_next = meta4_reg.atk ? (meta4_reg.prev + prod) : prod;
        rise       = meta4_reg.inr && meta4_reg.atk && (prod != '0);
        peak_next  = rise ? level_next[LF +: PKW] : meta4_reg.peak;
        out_tdata_next = '0;
        out_tdata_next[ppm_pkg::CH_W-1:0] = meta4_reg.ch;
        if (meta4_reg.inr)
        begin
            out_tdata_next[18:3]  = level_next[LF +: PKW];
            out_tdata_next[19]    = rise;
            out_tdata_next[35:20] = peak_next;
        end
    end

    assign wr_en          = v4_reg && ld_out && meta4_reg.inr;
    assign wr_entry.level = level_next;
    assign wr_entry.peak  = peak_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= accept;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
            if (ld_out)
            begin
                out_v_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch1_reg  <= in_ch;
            mag1_reg <= mag_next;
            be1_reg  <= s_tlast;
            inr1_reg <= in_inr;
        end
        if (ld2 && v1_reg)
        begin
            meta2_reg <= meta2_next;
            a2_reg    <= a2_next;
            c2_reg    <= c2_next;
        end
        if (ld3 && v2_reg)
        begin
            meta3_reg <= meta2_reg;
        end
        if (ld4 && v3_reg)
        begin
            meta4_reg <= meta3_reg;
        end
        if (ld_out && v4_reg)
        begin
            out_tdata_reg <= out_tdata_next;
            out_tlast_reg <= meta4_reg.be;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tlast  = out_tlast_reg;

endmodule

// ===== hdl/ppm_checker.sv =====
module ppm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [ppm_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ppm_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast,
    input logic                           cfg_we,
    input logic                           cfg_index,
    input logic [ppm_pkg::REG_W-1:0]      cfg_data
);

    // A stalled output word must hold until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Levels never exceed full scale.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[18:3] <= 16'd32768) && (m_tdata[35:20] <= 16'd32768))
        else $error("level or held peak above full scale");

    // A rising level becomes the held peak.
    a_rise_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19] |-> m_tdata[35:20] == m_tdata[18:3])
        else $error("held peak differs from rising level");

endmodule

bind peak_programme_meter_unit ppm_checker u_ppm_checker (.*);

// ===== tb/sv/tb_peak_programme_meter_unit.sv =====
module tb_peak_programme_meter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_W               = ppm_pkg::CH_W;
    localparam int SAMPLE_W           = ppm_pkg::SAMPLE_W;
    localparam int LEVEL_W            = ppm_pkg::LEVEL_W;
    localparam int LEVEL_FRAC         = ppm_pkg::LEVEL_FRAC;
    localparam int PEAK_W             = ppm_pkg::PEAK_W;
    localparam int REG_W              = ppm_pkg::REG_W;
    localparam int S_TDATA_W          = ppm_pkg::S_TDATA_W;
    localparam int M_TDATA_W          = ppm_pkg::M_TDATA_W;
    localparam int COEFF_FRAC_DEFAULT = ppm_pkg::COEFF_FRAC_DEFAULT;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_CH        = 2 ** CH_W;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_CFG,
        OP_DRAIN,
        OP_HOLD
    } op_t;

    typedef struct {
        op_t                 op;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
        logic                blk;
        int                  gap;
        ppm_pkg::reg_index_t idx;
        logic [REG_W-1:0]    val;
    } pending_t;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [PEAK_W-1:0] level;
        logic              rising;
        logic [PEAK_W-1:0] peak;
        logic              blk;
    } meter_out_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [REG_W-1:0]     cfg_data  = '0;
    logic                 hold_req  = 1'b0;

    pending_t   pending_q[$];
    meter_out_t meter_exp_q[$];

    logic [LEVEL_W-1:0] chan_level [NUM_CH];
    logic [PEAK_W-1:0]  chan_peak  [NUM_CH];
    logic [REG_W-1:0]   attack_k  = ppm_pkg::ATTACK_RESET;
    logic [REG_W-1:0]   release_k = ppm_pkg::RELEASE_RESET;

    int mismatches = 0;
    int cycle_cnt  = 0;
    int idle_cnt   = 0;
    int wait_cnt   = 0;
    int hold_left  = 0;
    int rx_left    = 0;
    int rx_count   = 0;
    bit rx_quiet   = 1'b0;

    peak_programme_meter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            chan_level[i] = '0;
            chan_peak[i]  = '0;
        end
    end

    function automatic logic [LEVEL_W-1:0] smooth_level(logic [LEVEL_W-1:0] prev,
            logic [SAMPLE_W-1:0] smp, logic [REG_W-1:0] atk, logic [REG_W-1:0] rel);
        logic [63:0] target;
        logic [63:0] prod;
        target = smp[SAMPLE_W-1] ? (64'h10000 - 64'(smp)) : 64'(smp);
        target = target << LEVEL_FRAC;
        if (64'(prev) > target)
        begin
            prod = 64'(prev) * ((64'd1 << COEFF_FRAC_DEFAULT) - 64'(rel));
            return LEVEL_W'(prod >> COEFF_FRAC_DEFAULT);
        end
        prod = (target - 64'(prev)) * 64'(atk);
        return LEVEL_W'(64'(prev) + (prod >> COEFF_FRAC_DEFAULT));
    endfunction

    task automatic record_word(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp, logic blk);
        logic [LEVEL_W-1:0] prev;
        logic [LEVEL_W-1:0] nxt;
        meter_out_t         res;
        prev = chan_level[ch];
        nxt  = smooth_level(prev, smp, attack_k, release_k);
        if (nxt > prev)
        begin
            chan_peak[ch] = nxt[LEVEL_FRAC +: PEAK_W];
        end
        chan_level[ch] = nxt;
        res.ch     = ch;
        res.level  = nxt[LEVEL_FRAC +: PEAK_W];
        res.rising = nxt > prev;
        res.peak   = chan_peak[ch];
        res.blk    = blk;
        meter_exp_q.push_back(res);
    endtask

    task automatic add_word(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp, logic blk, int gap);
        pending_t e;
        e = '{op: OP_WORD, ch: ch, smp: smp, blk: blk, gap: gap,
              idx: ppm_pkg::REG_ATTACK, val: '0};
        pending_q.push_back(e);
    endtask

    task automatic add_cfg(ppm_pkg::reg_index_t idx, logic [REG_W-1:0] val);
        pending_t e;
        e = '{op: OP_CFG, ch: '0, smp: '0, blk: 1'b0, gap: 0, idx: idx, val: val};
        pending_q.push_back(e);
    endtask

    task automatic add_op(op_t op);
        pending_t e;
        e = '{op: op, ch: '0, smp: '0, blk: 1'b0, gap: 0,
              idx: ppm_pkg::REG_ATTACK, val: '0};
        pending_q.push_back(e);
    endtask

    always @(posedge clk)
    begin : driver_p
        pending_t head;
        logic     valid_n;
        logic     we_n;
        logic     hold_n;
        if (rst_n)
        begin
            valid_n = s_tvalid;
            we_n    = 1'b0;
            hold_n  = 1'b0;
            if (s_tvalid && s_tready)
            begin
                record_word(s_tdata[CH_W-1:0], s_tdata[CH_W +: SAMPLE_W], s_tlast);
                valid_n = 1'b0;
            end
            if (meter_exp_q.size() == 0 && !valid_n)
            begin
                idle_cnt++;
            end
            else
            begin
                idle_cnt = 0;
            end
            if (!s_tvalid || s_tready)
            begin
                valid_n = 1'b0;
                if (pending_q.size() != 0)
                begin
                    head = pending_q[0];
                    case (head.op)
                        OP_WORD:
                        begin
                            if (wait_cnt < head.gap)
                            begin
                                wait_cnt++;
                            end
                            else
                            begin
                                valid_n  = 1'b1;
                                s_tdata <= {{(S_TDATA_W - SAMPLE_W - CH_W){1'b0}}, head.smp, head.ch};
                                s_tlast <= head.blk;
                                wait_cnt = 0;
                                void'(pending_q.pop_front());
                            end
                        end
                        OP_CFG:
                        begin
                            if (idle_cnt >= SETTLE_CYCLES)
                            begin
                                we_n       = 1'b1;
                                cfg_index <= head.idx;
                                cfg_data  <= head.val;
                                if (head.idx == ppm_pkg::REG_ATTACK)
                                begin
                                    attack_k = head.val;
                                end
                                else
                                begin
                                    release_k = head.val;
                                end
                                void'(pending_q.pop_front());
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (idle_cnt >= SETTLE_CYCLES)
                            begin
                                void'(pending_q.pop_front());
                            end
                        end
                        default:
                        begin
                            hold_n = 1'b1;
                            void'(pending_q.pop_front());
                        end
                    endcase
                end
            end
            s_tvalid <= valid_n;
            cfg_we   <= we_n;
            hold_req <= hold_n;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin : monitor_p
        meter_out_t got;
        meter_out_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.ch     = m_tdata[CH_W-1:0];
                got.level  = m_tdata[CH_W +: PEAK_W];
                got.rising = m_tdata[CH_W + PEAK_W];
                got.peak   = m_tdata[CH_W + PEAK_W + 1 +: PEAK_W];
                got.blk    = m_tlast;
                if (meter_exp_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected word: ch=%0d level=%0d rising=%0d peak=%0d last=%0d",
                                 got.ch, got.level, got.rising, got.peak, got.blk);
                    end
                    mismatches++;
                end
                else
                begin
                    want = meter_exp_q.pop_front();
                    if (got != want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("mismatch: expected ch=%0d level=%0d rising=%0d peak=%0d last=%0d",
                                     want.ch, want.level, want.rising, want.peak, want.blk);
                            $display("          actual   ch=%0d level=%0d rising=%0d peak=%0d last=%0d",
                                     got.ch, got.level, got.rising, got.peak, got.blk);
                        end
                        mismatches++;
                    end
                end
                rx_count++;
                if (rx_count % 64 == 0)
                begin
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                rx_left = rx_quiet ? 0 : int'($urandom_range(0, 16));
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
            end
            else if (rx_left != 0)
            begin
                rx_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus_p
        logic [REG_W-1:0]    atk;
        logic [REG_W-1:0]    rel;
        logic [CH_W-1:0]     ch;
        logic [CH_W-1:0]     ch_a;
        logic [CH_W-1:0]     ch_b;
        logic [SAMPLE_W-1:0] smp;
        int                  ch_mode;
        int                  count;
        int                  gap;
        bit                  tx_quiet;

        // Directed words under the reset coefficients, then under all-ones coefficients; a zero
        // sample on a fresh channel meets a level equal to the magnitude.
        add_word(3'd0, 16'h0000, 1'b0, 0);
        add_word(3'd1, 16'h7FFF, 1'b0, 0);
        add_word(3'd2, 16'h8000, 1'b0, 0);
        add_word(3'd3, 16'hFFFF, 1'b0, 0);
        add_word(3'd4, 16'h0001, 1'b0, 0);
        add_word(3'd5, 16'h4000, 1'b0, 0);
        add_word(3'd6, 16'hC000, 1'b0, 0);
        add_word(3'd7, 16'h0000, 1'b1, 0);
        add_word(3'd2, 16'h8000, 1'b0, 0);
        add_word(3'd2, 16'h8000, 1'b0, 0);
        add_word(3'd2, 16'h8000, 1'b0, 0);
        add_word(3'd2, 16'h0000, 1'b0, 0);
        add_word(3'd1, 16'h7FFF, 1'b1, 0);
        add_cfg(ppm_pkg::REG_ATTACK, '1);
        add_cfg(ppm_pkg::REG_RELEASE, '1);
        add_word(3'd2, 16'h8000, 1'b0, 0);
        add_word(3'd2, 16'h8000, 1'b0, 0);
        add_word(3'd2, 16'h0000, 1'b0, 0);
        add_word(3'd2, 16'h0000, 1'b1, 0);
        add_word(3'd5, 16'h7FFF, 1'b0, 0);
        add_word(3'd5, 16'h8001, 1'b1, 0);

        tx_quiet = 1'b0;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    atk = '1;
                    rel = '1;
                end
                1:
                begin
                    atk = '0;
                    rel = '0;
                end
                2:
                begin
                    atk = ppm_pkg::ATTACK_RESET;
                    rel = ppm_pkg::RELEASE_RESET;
                end
                default:
                begin
                    atk = REG_W'($urandom_range(24'hFFFFFF, 24'h040000));
                    rel = REG_W'($urandom_range(24'h100000, 0));
                end
            endcase
            add_cfg(ppm_pkg::REG_ATTACK, atk);
            add_cfg(ppm_pkg::REG_RELEASE, rel);
            count   = (p == 1) ? 100 : 215;
            ch_mode = int'($urandom_range(0, 2));
            ch_a    = CH_W'($urandom);
            ch_b    = CH_W'($urandom);
            for (int n = 0; n < count; n++)
            begin
                if (n % 50 == 0)
                begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                end
                if (p == 3 && n == 40)
                begin
                    add_op(OP_HOLD);
                end
                if (p == 4 && n == 100)
                begin
                    add_op(OP_DRAIN);
                end
                case (ch_mode)
                    0: ch = CH_W'($urandom);
                    1: ch = $urandom_range(0, 1) ? ch_a : ch_b;
                    default: ch = ch_a;
                endcase
                case ($urandom_range(0, 3))
                    0: smp = SAMPLE_W'($urandom);
                    1: smp = $urandom_range(0, 1)
                           ? SAMPLE_W'(16'h8000 + $urandom_range(0, 3))
                           : SAMPLE_W'(16'h7FFF - $urandom_range(0, 3));
                    2: smp = SAMPLE_W'($urandom_range(0, 511) - 256);
                    default: smp = '0;
                endcase
                gap = (tx_quiet || (p == 3 && n >= 40 && n < 100))
                    ? 0 : int'($urandom_range(0, 16));
                add_word(ch, smp, $urandom_range(0, 7) == 0, gap);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid || meter_exp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (meter_exp_q.size() != 0)
        begin
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
